// File: rtl/core/s256_pkg.sv
// s256_pkg: shared types, constants and helper functions for the sha-256 stream digest
// no dependencies
package s256_pkg;

	typedef logic [15:0][31:0] s256_words_t;

	typedef struct packed {
		s256_words_t words;
		logic        last;
	} s256_job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_FLUSH,
		F_PAD,
		F_EXTRA
	} s256_front_st_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ROUND,
		B_ADD,
		B_EMIT
	} s256_back_st_t;

	localparam int CNT_W = 61;

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			3'd7: v = 32'h5be0cd19;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_const(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// keep bytes below pos, put the 0x80 marker at pos, zero the rest
	function automatic s256_words_t pad_words(input s256_words_t b, input logic [5:0] pos);
		s256_words_t o;
		for (int i = 0; i < 16; i++) begin
			if (4'(i) < pos[5:2]) begin
				o[i] = b[i];
			end else if (4'(i) == pos[5:2]) begin
				case (pos[1:0])
					2'd0: o[i] = 32'h80000000;
					2'd1: o[i] = (b[i] & 32'hff000000) | 32'h00800000;
					2'd2: o[i] = (b[i] & 32'hffff0000) | 32'h00008000;
					2'd3: o[i] = (b[i] & 32'hffffff00) | 32'h00000080;
					default: o[i] = 32'h0;
				endcase
			end else begin
				o[i] = 32'h0;
			end
		end
		return o;
	endfunction

endpackage

// File: rtl/core/s256_front.sv
// s256_front: packs bytes into blocks, counts the message and builds padding blocks
// depends on s256_pkg
module s256_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          message_byte,
	input  logic                byte_present,
	input  logic                end_of_message,
	input  logic                push,
	output logic                full,
	output s256_pkg::s256_job_t job,
	output logic                job_push,
	input  logic                job_full
);
	import s256_pkg::*;

	s256_front_st_t         st_q, st_nxt;
	s256_words_t            blk_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   last_q;
	logic                   accept;
	logic [CNT_W-1:0]       cnt_inc;
	logic [63:0]            bit_len;
	s256_words_t            padded;
	logic                   pad_fits;

	assign accept   = push && !full;
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign bit_len  = {cnt_q, 3'b000};
	assign padded   = pad_words(blk_q, cnt_q[5:0]);
	assign pad_fits = cnt_q[5:0] < 6'd56;

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			F_IDLE: begin
				if (accept) begin
					if (byte_present && cnt_inc[5:0] == 6'd0) begin
						st_nxt = F_FLUSH;
					end else if (end_of_message) begin
						st_nxt = F_PAD;
					end
				end
			end
			F_FLUSH: begin
				if (!job_full) begin
					st_nxt = last_q ? F_PAD : F_IDLE;
				end
			end
			F_PAD: begin
				if (!job_full) begin
					st_nxt = pad_fits ? F_IDLE : F_EXTRA;
				end
			end
			F_EXTRA: begin
				if (!job_full) begin
					st_nxt = F_IDLE;
				end
			end
			default: st_nxt = F_IDLE;
		endcase
	end

	// outputs toward the sender and the job queue
	always_comb begin
		full     = 1'b1;
		job_push = 1'b0;
		job      = '{words: blk_q, last: 1'b0};
		case (st_q)
			F_IDLE: full = 1'b0;
			F_FLUSH: job_push = !job_full;
			F_PAD: begin
				job_push = !job_full;
				job.words = padded;
				if (pad_fits) begin
					job.words[14] = bit_len[63:32];
					job.words[15] = bit_len[31:0];
					job.last      = 1'b1;
				end
			end
			F_EXTRA: begin
				job_push       = !job_full;
				job.words      = '0;
				job.words[14]  = bit_len[63:32];
				job.words[15]  = bit_len[31:0];
				job.last       = 1'b1;
			end
			default: full = 1'b1;
		endcase
	end

	// state, count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (accept) begin
				last_q <= end_of_message;
				if (byte_present) begin
					cnt_q <= cnt_inc;
				end
			end
			if (job_push && job.last) begin
				cnt_q <= '0;
			end
		end
	end

	// byte lanes of the open block
	always_ff @(posedge clk) begin
		if (accept && byte_present) begin
			blk_q[cnt_q[5:2]][8*(3-cnt_q[1:0]) +: 8] <= message_byte;
		end
	end

endmodule

// File: rtl/core/s256_jobq.sv
// s256_jobq: two-entry queue of blocks between front and compression core
// depends on s256_pkg
module s256_jobq (
	input  logic                clk,
	input  logic                arst_n,
	input  s256_pkg::s256_job_t wr_job,
	input  logic                wr_en,
	output logic                q_full,
	output s256_pkg::s256_job_t rd_job,
	output logic                q_empty,
	input  logic                rd_en
);
	import s256_pkg::*;

	s256_job_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign rd_job  = mem_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= !wp_q;
			if (rd_en) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_job;
	end

endmodule

// File: rtl/core/s256_back.sv
// s256_back: 64-round compression, one round per cycle, and digest word output
// depends on s256_pkg
module s256_back (
	input  logic                clk,
	input  logic                arst_n,
	input  s256_pkg::s256_job_t job,
	input  logic                job_empty,
	output logic                job_pop,
	output logic [31:0]         digest_word,
	output logic [2:0]          word_number,
	output logic                final_word,
	output logic                empty,
	input  logic                pop
);
	import s256_pkg::*;

	s256_back_st_t    st_q, st_nxt;
	logic [31:0]      h_q  [8];
	logic [31:0]      v_q  [8];
	logic [31:0]      win_q[16];
	logic [5:0]       rnd_q;
	logic [2:0]       oidx_q;
	logic             last_q;
	logic [31:0]      w_new, t1, t2, s0, s1, ep, ch, mj, e, a;

	assign a = v_q[0];
	assign e = v_q[4];

	// schedule expansion and round function
	always_comb begin
		s0    = {win_q[1][6:0], win_q[1][31:7]} ^ {win_q[1][17:0], win_q[1][31:18]}
		      ^ (win_q[1] >> 3);
		s1    = {win_q[14][16:0], win_q[14][31:17]} ^ {win_q[14][18:0], win_q[14][31:19]}
		      ^ (win_q[14] >> 10);
		w_new = s1 + win_q[9] + s0 + win_q[0];
		ep    = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		ch    = (e & v_q[5]) ^ (~e & v_q[6]);
		t1    = v_q[7] + ep + ch + round_const(rnd_q) + win_q[0];
		mj    = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]}) + mj;
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			B_IDLE:  if (!job_empty) st_nxt = B_ROUND;
			B_ROUND: if (rnd_q == 6'd63) st_nxt = B_ADD;
			B_ADD:   st_nxt = last_q ? B_EMIT : B_IDLE;
			B_EMIT:  if (pop && oidx_q == 3'd7) st_nxt = B_IDLE;
			default: st_nxt = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_pop     = 1'b0;
		empty       = 1'b1;
		digest_word = h_q[oidx_q];
		word_number = oidx_q;
		final_word  = oidx_q == 3'd7;
		case (st_q)
			B_IDLE:  job_pop = !job_empty;
			B_EMIT:  empty   = 1'b0;
			default: empty   = 1'b1;
		endcase
	end

	// control state and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			rnd_q  <= '0;
			oidx_q <= '0;
			last_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else begin
			st_q <= st_nxt;
			case (st_q)
				B_IDLE: begin
					rnd_q  <= '0;
					oidx_q <= '0;
					if (!job_empty) last_q <= job.last;
				end
				B_ROUND: rnd_q <= rnd_q + 6'd1;
				B_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				B_EMIT: begin
					if (pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
						end
					end
				end
				default: rnd_q <= '0;
			endcase
		end
	end

	// working words and schedule window
	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && !job_empty) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < 16; i++) win_q[i] <= job.words[i];
		end else if (st_q == B_ROUND) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

// File: rtl/core/sha256_stream_digest.sv
// sha256_stream_digest: top level, byte front end, block queue and compression core
// depends on s256_pkg, s256_front, s256_jobq, s256_back
// throughput: one byte item per cycle while full is low; the front stalls after each 64th
// byte while it hands the block on, and after an end item while it builds padding; the core
// loads each block, runs the 64 rounds and does the chaining add, so long messages are paced
// by the core once the block queue is full. With the core idle the first digest word
// appears once one or two padding blocks pass the round unit; words leave one per pop
// reset: arst_n clears all control state and loads the initial hash values at once
module sha256_stream_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        push,
	output logic        full,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word,
	output logic        empty,
	input  logic        pop
);
	import s256_pkg::*;

	s256_job_t wr_job, rd_job;
	logic      wr_en, q_full, q_empty, rd_en;

	// byte packing and padding
	s256_front u_front (
		.clk, .arst_n, .message_byte, .byte_present, .end_of_message, .push, .full,
		.job(wr_job), .job_push(wr_en), .job_full(q_full)
	);

	// block queue
	s256_jobq u_jobq (
		.clk, .arst_n, .wr_job, .wr_en, .q_full, .rd_job, .q_empty, .rd_en
	);

	// compression and digest output
	s256_back u_back (
		.clk, .arst_n, .job(rd_job), .job_empty(q_empty), .job_pop(rd_en),
		.digest_word, .word_number, .final_word, .empty, .pop
	);

endmodule

// File: tb/sv/sha256_digest_checker.sv
`timescale 1ns / 1ps
// sha256_digest_checker: watches the byte and digest channels, predicts sha-256 digests
// and compares them word by word; depends on nothing but the port widths of the block
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        push,
	input  logic        full,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_number,
	input  logic        final_word,
	input  logic        empty,
	input  logic        pop,
	output int          fail_count,
	output int          pending_words
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  number;
		logic        last;
	} digest_item_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [31:0] START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	logic [31:0]  hash_state [8];
	logic [31:0]  msg_block [16];
	logic [60:0]  byte_total;
	digest_item_t digest_queue [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of msg_block into hash_state
	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wr, s0, s1, t1, t2;
		for (int i = 0; i < 16; i++) w[i] = msg_block[i];
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				s0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
				s1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
				wr = w[r&15] + s0 + w[(r-7)&15] + s1;
				w[r&15] = wr;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
	endtask

	// absorb one byte item, finish the digest on the end mark
	task automatic absorb_item(input logic [7:0] b, input logic present, input logic eom);
		int pos;
		logic [63:0] bit_len;
		digest_item_t d;
		if (present) begin
			pos = int'(byte_total[5:0]);
			if (pos % 4 == 0) msg_block[pos/4] = {b, 24'h0};
			else msg_block[pos/4] |= 32'(b) << (24 - 8 * (pos % 4));
			byte_total = byte_total + 61'd1;
			if (byte_total[5:0] == 6'd0) compress_block();
		end
		if (eom) begin
			pos = int'(byte_total[5:0]);
			if (pos % 4 == 0) msg_block[pos/4] = 32'h80000000;
			else msg_block[pos/4] = (msg_block[pos/4] & (32'hffffffff << (32 - 8 * (pos % 4))))
				| (32'h80 << (24 - 8 * (pos % 4)));
			for (int i = pos / 4 + 1; i < 16; i++) msg_block[i] = 32'h0;
			if (pos >= 56) begin
				compress_block();
				for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
			end
			bit_len = {byte_total, 3'b000};
			msg_block[14] = bit_len[63:32];
			msg_block[15] = bit_len[31:0];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				d.word = hash_state[i];
				d.number = 3'(i);
				d.last = (i == 7);
				digest_queue.push_back(d);
			end
			for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
			byte_total = '0;
		end
	endtask

	assign pending_words = digest_queue.size();

	// sample both channels at the edge
	always @(posedge clk or negedge arst_n) begin
		digest_item_t exp_d;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
			byte_total = '0;
			digest_queue.delete();
			fail_count = 0;
		end else begin
			if (push && !full) absorb_item(message_byte, byte_present, end_of_message);
			if (pop && !empty) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: digest word %h with none expected", $time, digest_word);
					fail_count++;
				end else begin
					exp_d = digest_queue.pop_front();
					if (digest_word !== exp_d.word || word_number !== exp_d.number
						|| final_word !== exp_d.last) begin
						$display("%0t: expected word %h num %0d last %0b, got %h num %0d last %0b",
							$time, exp_d.word, exp_d.number, exp_d.last,
							digest_word, word_number, final_word);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for sha256_stream_digest
// depends on sha256_stream_digest and sha256_digest_checker
module tb;

	localparam int IDLE_LIMIT = 20000;
	localparam int ITEM_TARGET = 270;

	logic        clk;
	logic        arst_n;
	logic [7:0]  message_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        push;
	logic        full;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;
	logic        empty;
	logic        pop;
	int          fail_count;
	int          pending_words;
	int          idle_cycles;
	bit          hold_receiver;
	bit          long_hold_done;

	sha256_stream_digest u_dut (.*);

	sha256_digest_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: own stall pattern, one long hold on request
	initial begin
		int hold;
		pop = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_receiver && !long_hold_done) begin
				pop <= 0;
				for (hold = 0; hold < 400; hold++) @(posedge clk);
				long_hold_done = 1;
			end
			pop <= ($urandom_range(0, 3) != 0) || ($time / 5000) % 3 == 0;
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// offer one item, hold it until accepted
	task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
		push <= 1;
		message_byte <= b;
		byte_present <= present;
		end_of_message <= eom;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// sender gap between bursts
	task automatic maybe_gap(inout int burst);
		int gap;
		if (burst > 0) begin
			burst--;
			return;
		end
		burst = int'($urandom_range(1, 40));
		gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_message(input int len, inout int burst);
		for (int i = 0; i < len; i++) begin
			maybe_gap(burst);
			send_item(8'($urandom), 1'b1, (i == len - 1));
		end
	endtask

	initial begin
		int burst;
		int sent;
		int len;
		idle_cycles = 0;
		hold_receiver = 0;
		long_hold_done = 0;
		burst = 0;
		arst_n = 0;
		push = 0;
		message_byte = 0;
		byte_present = 0;
		end_of_message = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// empty message, byte extremes, ignored item, end without byte
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b1);
		// padding boundaries: 55, 56, 63, 64 bytes
		send_message(55, burst);
		send_message(56, burst);
		// long receiver hold while bytes keep flowing
		hold_receiver = 1;
		send_message(63, burst);
		send_message(64, burst);
		send_message(3, burst);
		// sender pauses until all digests are drained
		push <= 0;
		while (pending_words != 0 || !long_hold_done) @(posedge clk);
		// items offered so far
		sent = 247;
		while (sent < ITEM_TARGET) begin
			len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 130))
				: int'($urandom_range(0, 20));
			if (len > ITEM_TARGET - sent) len = ITEM_TARGET - sent;
			if ($urandom_range(0, 9) == 0) begin
				maybe_gap(burst);
				send_item(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
				sent++;
			end
			if (len == 0) begin
				send_item(8'($urandom), 1'b0, 1'b1);
				sent++;
			end else begin
				send_message(len, burst);
				sent += len;
			end
		end
		push <= 0;
		while (pending_words != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
rtl/core/s256_pkg.sv
rtl/core/s256_front.sv
rtl/core/s256_jobq.sv
rtl/core/s256_back.sv
rtl/core/sha256_stream_digest.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb.sv
